/* hdl/sal_pkg.sv */
// Shared types and constants for the source attempt limiter.
// Used by sal_ctrl, sal_datapath and source_attempt_limiter; depends on nothing.
package sal_pkg;

  localparam int COUNT_ENTRIES = 64;
  localparam int BLOCK_ENTRIES = 16;

  localparam int COUNT_IW = $clog2(COUNT_ENTRIES);
  localparam int BLOCK_IW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int SCAN_MAX = (COUNT_ENTRIES > BLOCK_ENTRIES) ? COUNT_ENTRIES : BLOCK_ENTRIES;
  localparam int SCAN_W   = $clog2(SCAN_MAX + 1);

  localparam int ADDR_W   = 32;
  localparam int CNT_W    = 17;
  localparam int CFG_W    = 16;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 17'h10000;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ALLOWED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNBLOCKED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NEW_BLOCK = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_ENABLE         = 2'd0;
  localparam logic [INDEX_W-1:0] REG_ATTEMPT_LIMIT  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_BLOCK_SECONDS  = 2'd2;
  localparam logic [INDEX_W-1:0] REG_CLEAR_INTERVAL = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_START  = 8'b0000_0010,
    S_BSCAN  = 8'b0000_0100,
    S_BCHECK = 8'b0000_1000,
    S_CSCAN  = 8'b0001_0000,
    S_CCHECK = 8'b0010_0000,
    S_LIMIT  = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic                load_item;
    logic                scan_start;
    logic                scan_block;
    logic                scan_count;
    logic                tick;
    logic                unblock;
    logic                count_update;
    logic                block_insert;
    logic                res_load;
    logic                res_refused;
    logic [STATUS_W-1:0] res_status;
    logic                res_use_count;
    logic                emit;
  } cmd_t;

  typedef struct packed {
    logic op_tick;
    logic enable;
    logic scan_done;
    logic block_hit;
    logic block_expired;
    logic count_hit;
    logic count_free;
    logic over_limit;
    logic block_free;
    logic out_free;
  } stat_t;

endpackage

/* hdl/sal_datapath.sv */
// Datapath of the source attempt limiter: configuration registers, time keeping,
// count and block tables, table scanner and result registers. Depends on sal_pkg.
module sal_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  sal_pkg::cmd_t                  cmd,
  output sal_pkg::stat_t                 stat,
  input  logic                           op,
  input  logic [sal_pkg::ADDR_W-1:0]     source_addr,
  input  logic                           cfg_valid,
  input  logic [sal_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [sal_pkg::CFG_W-1:0]      cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           refused,
  output logic [sal_pkg::STATUS_W-1:0]   status,
  output logic [sal_pkg::CNT_W-1:0]      attempt_count
);

  // Configuration.
  logic                       enable;
  logic [sal_pkg::CFG_W-1:0]  attempt_limit;
  logic [sal_pkg::CFG_W-1:0]  block_seconds;
  logic [sal_pkg::CFG_W-1:0]  clear_interval;

  // Time.
  logic [31:0]                now_seconds;
  logic [sal_pkg::CFG_W-1:0]  clear_countdown;
  logic [sal_pkg::CFG_W-1:0]  countdown_next;
  logic [sal_pkg::CFG_W-1:0]  interval_eff;

  // Current item.
  logic                       op_q;
  logic [sal_pkg::ADDR_W-1:0] addr_q;

  // Tables. Key and value, or key and stamp, share one memory word.
  logic [sal_pkg::COUNT_ENTRIES-1:0] count_valid;
  logic [sal_pkg::BLOCK_ENTRIES-1:0] block_valid;
  logic [sal_pkg::ADDR_W+sal_pkg::CNT_W-1:0] cmem [sal_pkg::COUNT_ENTRIES];
  logic [sal_pkg::ADDR_W+32-1:0]             bmem [sal_pkg::BLOCK_ENTRIES];
  logic [sal_pkg::ADDR_W+sal_pkg::CNT_W-1:0] cmem_q;
  logic [sal_pkg::ADDR_W+32-1:0]             bmem_q;

  // Scanner.
  logic [sal_pkg::SCAN_W-1:0] scan_idx;
  logic [sal_pkg::SCAN_W-1:0] scan_end;
  logic [sal_pkg::SCAN_W-1:0] rd_idx;
  logic                       rd_pend;
  logic                       issue;

  // Search results.
  logic                        block_hit;
  logic [sal_pkg::BLOCK_IW-1:0] block_slot;
  logic [31:0]                 block_stamp;
  logic                        block_free;
  logic [sal_pkg::BLOCK_IW-1:0] block_free_slot;
  logic                        count_hit;
  logic [sal_pkg::COUNT_IW-1:0] count_slot;
  logic [sal_pkg::CNT_W-1:0]   count_old;
  logic                        count_free;
  logic [sal_pkg::COUNT_IW-1:0] count_free_slot;

  logic [sal_pkg::COUNT_IW-1:0] upd_slot;
  logic [sal_pkg::CNT_W-1:0]    upd_base;
  logic [sal_pkg::CNT_W-1:0]    count_next;
  logic [sal_pkg::CNT_W-1:0]    new_count;
  logic [31:0]                  elapsed;

  // Pending result, waiting for the output register.
  logic                         res_refused;
  logic [sal_pkg::STATUS_W-1:0] res_status;
  logic [sal_pkg::CNT_W-1:0]    res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      attempt_limit  <= 16'd10;
      block_seconds  <= 16'd60;
      clear_interval <= 16'd60;
    end else if (cfg_valid) begin
      case (cfg_index)
        sal_pkg::REG_ENABLE:         enable         <= cfg_data[0];
        sal_pkg::REG_ATTEMPT_LIMIT:  attempt_limit  <= cfg_data;
        sal_pkg::REG_BLOCK_SECONDS:  block_seconds  <= cfg_data;
        sal_pkg::REG_CLEAR_INTERVAL: clear_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  assign interval_eff   = (clear_interval == '0) ? 16'd1 : clear_interval;
  assign countdown_next = clear_countdown + 16'd1;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q   <= op;
      addr_q <= source_addr;
    end
  end

  // Scanner: one read issued per cycle, compared in the cycle after it is issued.
  assign scan_end = cmd.scan_block ? sal_pkg::SCAN_W'(sal_pkg::BLOCK_ENTRIES)
                                   : sal_pkg::SCAN_W'(sal_pkg::COUNT_ENTRIES);
  assign issue    = (cmd.scan_block || cmd.scan_count) && (scan_idx < scan_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (issue) begin
        rd_idx   <= scan_idx;
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_block && issue) begin
      bmem_q <= bmem[scan_idx[sal_pkg::BLOCK_IW-1:0]];
    end
    if (cmd.block_insert) begin
      bmem[block_free_slot] <= {addr_q, now_seconds};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_count && issue) begin
      cmem_q <= cmem[scan_idx[sal_pkg::COUNT_IW-1:0]];
    end
    if (cmd.count_update) begin
      cmem[upd_slot] <= {addr_q, count_next};
    end
  end

  // Search result capture.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      block_hit  <= 1'b0;
      block_free <= 1'b0;
      count_hit  <= 1'b0;
      count_free <= 1'b0;
    end else if (rd_pend && cmd.scan_block) begin
      if (block_valid[rd_idx[sal_pkg::BLOCK_IW-1:0]]) begin
        if (bmem_q[63:32] == addr_q) begin
          block_hit   <= 1'b1;
          block_slot  <= rd_idx[sal_pkg::BLOCK_IW-1:0];
          block_stamp <= bmem_q[31:0];
        end
      end else if (!block_free) begin
        block_free      <= 1'b1;
        block_free_slot <= rd_idx[sal_pkg::BLOCK_IW-1:0];
      end
    end else if (rd_pend && cmd.scan_count) begin
      if (count_valid[rd_idx[sal_pkg::COUNT_IW-1:0]]) begin
        if (cmem_q[sal_pkg::ADDR_W+sal_pkg::CNT_W-1:sal_pkg::CNT_W] == addr_q) begin
          count_hit  <= 1'b1;
          count_slot <= rd_idx[sal_pkg::COUNT_IW-1:0];
          count_old  <= cmem_q[sal_pkg::CNT_W-1:0];
        end
      end else if (!count_free) begin
        count_free      <= 1'b1;
        count_free_slot <= rd_idx[sal_pkg::COUNT_IW-1:0];
      end
    end
  end

  assign upd_slot   = count_hit ? count_slot : count_free_slot;
  assign upd_base   = count_hit ? count_old : '0;
  assign count_next = (upd_base == sal_pkg::COUNT_MAX) ? upd_base : upd_base + 1'b1;
  assign elapsed    = now_seconds - block_stamp;

  always_ff @(posedge clk) begin
    if (cmd.count_update) begin
      new_count <= count_next;
    end
  end

  // Time keeping and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      now_seconds     <= '0;
      clear_countdown <= '0;
      count_valid     <= '0;
      block_valid     <= '0;
    end else begin
      if (cmd.tick) begin
        now_seconds <= now_seconds + 32'd1;
        if (countdown_next >= interval_eff) begin
          clear_countdown <= '0;
          count_valid     <= '0;
        end else begin
          clear_countdown <= countdown_next;
        end
      end
      if (cmd.count_update) begin
        count_valid[upd_slot] <= 1'b1;
      end
      if (cmd.unblock) begin
        block_valid[block_slot] <= 1'b0;
      end
      if (cmd.block_insert) begin
        block_valid[block_free_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_refused <= cmd.res_refused;
      res_status  <= cmd.res_status;
      res_count   <= cmd.res_use_count ? new_count : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      refused       <= res_refused;
      status        <= res_status;
      attempt_count <= res_count;
    end
  end

  assign stat.op_tick       = op_q;
  assign stat.enable        = enable;
  assign stat.scan_done     = (scan_idx == scan_end) && !rd_pend;
  assign stat.block_hit     = block_hit;
  assign stat.block_expired = elapsed > {16'd0, block_seconds};
  assign stat.count_hit     = count_hit;
  assign stat.count_free    = count_free;
  assign stat.over_limit    = new_count > {1'b0, attempt_limit};
  assign stat.block_free    = block_free;
  assign stat.out_free      = !out_valid || out_ready;

endmodule

/* hdl/sal_ctrl.sv */
// Controller state machine of the source attempt limiter.
// Sequences the datapath through block search, count search and update. Depends on sal_pkg.
module sal_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sal_pkg::stat_t stat,
  output sal_pkg::cmd_t  cmd
);

  sal_pkg::state_t state;
  sal_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sal_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == sal_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      sal_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = sal_pkg::S_START;
        end
      end
      sal_pkg::S_START: begin
        if (stat.op_tick) begin
          cmd.tick   = 1'b1;
          state_next = sal_pkg::S_IDLE;
        end else if (!stat.enable) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = sal_pkg::ST_ALLOWED;
          state_next     = sal_pkg::S_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = sal_pkg::S_BSCAN;
        end
      end
      sal_pkg::S_BSCAN: begin
        cmd.scan_block = 1'b1;
        if (stat.scan_done) begin
          state_next = sal_pkg::S_BCHECK;
        end
      end
      sal_pkg::S_BCHECK: begin
        if (stat.block_hit) begin
          cmd.res_load = 1'b1;
          if (stat.block_expired) begin
            cmd.unblock    = 1'b1;
            cmd.res_status = sal_pkg::ST_UNBLOCKED;
          end else begin
            cmd.res_refused = 1'b1;
            cmd.res_status  = sal_pkg::ST_BLOCKED;
          end
          state_next = sal_pkg::S_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = sal_pkg::S_CSCAN;
        end
      end
      sal_pkg::S_CSCAN: begin
        cmd.scan_count = 1'b1;
        if (stat.scan_done) begin
          state_next = sal_pkg::S_CCHECK;
        end
      end
      sal_pkg::S_CCHECK: begin
        if (!stat.count_hit && !stat.count_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = sal_pkg::ST_FULL;
          state_next     = sal_pkg::S_EMIT;
        end else begin
          cmd.count_update = 1'b1;
          state_next       = sal_pkg::S_LIMIT;
        end
      end
      sal_pkg::S_LIMIT: begin
        cmd.res_load      = 1'b1;
        cmd.res_use_count = 1'b1;
        if (stat.over_limit) begin
          if (stat.block_free) begin
            cmd.block_insert = 1'b1;
            cmd.res_refused  = 1'b1;
            cmd.res_status   = sal_pkg::ST_NEW_BLOCK;
          end else begin
            cmd.res_status = sal_pkg::ST_FULL;
          end
        end else begin
          cmd.res_status = sal_pkg::ST_ALLOWED;
        end
        state_next = sal_pkg::S_EMIT;
      end
      sal_pkg::S_EMIT: begin
        // Wait until the output register has room for this result.
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sal_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sal_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/source_attempt_limiter.sv */
// Per-source connection attempt limiter, top level.
// A tick advances time and gives no result. An attempt is paced by the
// one-entry-per-cycle scan of the block table and then the count table.
// One item is in work at a time.
// Synchronous reset clears configuration to defaults, time, and all table valid bits.
module source_attempt_limiter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic [sal_pkg::ADDR_W-1:0]     source_addr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           refused,
  output logic [sal_pkg::STATUS_W-1:0]   status,
  output logic [sal_pkg::CNT_W-1:0]      attempt_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sal_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [sal_pkg::CFG_W-1:0]      cfg_data
);

  sal_pkg::cmd_t  cmd;
  sal_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  sal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sal_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .source_addr   (source_addr),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .refused       (refused),
    .status        (status),
    .attempt_count (attempt_count)
  );

endmodule
